[src/rvm_pkg.sv]
`timescale 1ns / 1ps
package rvm_pkg;

  typedef enum logic [5:0] {
    OP_NOP = 6'd0, OP_INT = 6'd1, OP_HALT = 6'd2, OP_LOAD = 6'd3, OP_LOADI = 6'd4,
    OP_STORE = 6'd5, OP_STOREI = 6'd6, OP_SET = 6'd7, OP_ADD = 6'd8, OP_SUB = 6'd9,
    OP_MUL = 6'd10, OP_DIV = 6'd11, OP_MOD = 6'd12, OP_CMP = 6'd13, OP_AND = 6'd14,
    OP_OR = 6'd15, OP_XOR = 6'd16, OP_NOT = 6'd17, OP_SHL = 6'd18, OP_SHR = 6'd19,
    OP_JMP = 6'd20, OP_JMPR = 6'd21, OP_JZ = 6'd22, OP_JNZ = 6'd23, OP_JC = 6'd24,
    OP_JNC = 6'd25, OP_JS = 6'd26, OP_JNS = 6'd27, OP_JO = 6'd28, OP_JNO = 6'd29,
    OP_PUSH = 6'd30, OP_POP = 6'd31, OP_CALL = 6'd32, OP_CALLR = 6'd33, OP_RET = 6'd34
  } opcode_t;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0, EV_PCHAR = 3'd1, EV_PINT = 3'd2, EV_DISP = 3'd3,
    EV_BADOP = 3'd4, EV_BADINT = 3'd5, EV_RANGE = 3'd6
  } event_t;

  localparam int FL_Z = 0;
  localparam int FL_N = 1;
  localparam int FL_C = 2;
  localparam int FL_V = 3;
  localparam int FL_D = 4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_MEMRD, ST_WB, ST_DONE, ST_CLEAR
  } state_t;

  typedef struct packed {
    logic        start;
    logic        is_signed_neg_q;
    logic        is_signed_neg_r;
  } div_ctrl_t;

endpackage

[src/rvm_divider.sv]
`timescale 1ns / 1ps
module rvm_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  rvm_pkg::div_ctrl_t   ctrl,
  input  logic [31:0]          dividend_mag,
  input  logic [31:0]          divisor_mag,
  output logic                 busy,
  output logic [31:0]          quotient,
  output logic [31:0]          remainder
);
  import rvm_pkg::*;

  // Restoring division on magnitudes, one quotient bit per cycle.
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic        neg_q;
  logic        neg_r;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.start) begin
      count <= 6'd32;
    end else if (count != '0) begin
      count <= count - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo   <= dividend_mag;
      rem   <= '0;
      dvs   <= divisor_mag;
      neg_q <= ctrl.is_signed_neg_q;
      neg_r <= ctrl.is_signed_neg_r;
    end else if (count != '0) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign busy      = ctrl.start || (count != '0);
  assign quotient  = neg_q ? (32'd0 - quo) : quo;
  assign remainder = neg_r ? (32'd0 - rem) : rem;
endmodule

[src/register_vm_instruction_executor_unit.sv]
`timescale 1ns / 1ps
// Each instruction steps through READ, EXEC, MEMRD, WB and DONE, where strobe is raised;
// a multiply adds MUL (registered product), and a divide or modulo by a nonzero divisor
// adds DIV, which waits on a one-bit-per-cycle divider. One instruction at a time: a new
// one is taken only in IDLE. The receiver cannot stall; strobe is high for a single cycle.
// Reset is synchronous; a clearing pass then zeroes data memory and the register file,
// one word per cycle through all MEM_WORDS words, with busy high.
module register_vm_instruction_executor_unit #(
  parameter int MEM_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [5:0]  opcode,
  input  logic [3:0]  dest_reg,
  input  logic [3:0]  src_reg_a,
  input  logic [3:0]  src_reg_b,
  input  logic [31:0] immediate,
  input  logic [31:0] preload_address,
  input  logic [31:0] preload_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        strobe,
  output logic [31:0] next_pc,
  output logic        done_res,
  output logic [2:0]  event_res,
  output logic [31:0] event_value,
  output logic [4:0]  flag_bits
);
  import rvm_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  // Data memory is single ported with a registered read; the register file is a small
  // memory read at three addresses, so it is kept as three copies written together.
  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] rf_a [16];
  logic [31:0] rf_b [16];
  logic [31:0] rf_d [16];

  state_t state, state_next;

  logic [31:0] prog_len;
  logic [31:0] pc;
  logic [4:0]  flags;
  logic [AW-1:0] sp;
  logic [AW:0]   clr_cnt;

  // Latched instruction.
  logic        act_q;
  logic [5:0]  op_q;
  logic [3:0]  d_q;
  logic [31:0] imm_q;
  logic [31:0] pa_q;
  logic [31:0] pv_q;
  logic [3:0]  a_idx;
  logic [3:0]  b_idx;

  logic [31:0] ra, rb, rd, r0v;
  logic [31:0] r0;

  // Memory port controls.
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;
  logic          rf_we;
  logic [3:0]    rf_waddr;
  logic [31:0]   rf_wdata;

  // Decision registers computed in EXEC, and updated in MEMRD for a multiply and in DIV.
  logic [31:0] pc_new;
  logic [4:0]  flags_new;
  logic [2:0]  ev_q;
  logic [31:0] evv_q;
  logic        wr_rf_q;
  logic [31:0] wr_val_q;
  logic        rf_from_mem;
  logic        pc_from_mem;
  logic [AW-1:0] mem_addr_q;
  logic        mem_we_q;
  logic [31:0] mem_wd_q;
  logic [AW-1:0] sp_new;

  logic [63:0] prod;
  logic        div_busy;
  logic [31:0] div_q, div_r;
  div_ctrl_t   dctl;

  assign cfg_ready = (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len <= '0;
    end else if (cfg_valid && cfg_ready) begin
      prog_len <= cfg_data;
    end
  end

  // Register file write port and reads (registered).
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_a[rf_waddr] <= rf_wdata;
      rf_b[rf_waddr] <= rf_wdata;
      rf_d[rf_waddr] <= rf_wdata;
    end
    if (rf_we && rf_waddr == 4'd0) begin
      r0 <= rf_wdata;
    end
    ra  <= rf_a[a_idx];
    rb  <= rf_b[b_idx];
    rd  <= rf_d[d_q];
    r0v <= r0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= dmem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_q <= action;
      op_q  <= opcode;
      d_q   <= dest_reg;
      a_idx <= src_reg_a;
      b_idx <= src_reg_b;
      imm_q <= immediate;
      pa_q  <= preload_address;
      pv_q  <= preload_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Sign handling for the divider.
  logic        neg_a, neg_b;
  logic [31:0] mag_a, mag_b;
  assign neg_a = ra[31];
  assign neg_b = rb[31];
  assign mag_a = neg_a ? (32'd0 - ra) : ra;
  assign mag_b = neg_b ? (32'd0 - rb) : rb;
  assign dctl = '{
    start: (state == ST_EXEC) && (op_q == OP_DIV || op_q == OP_MOD)
           && (rb != '0) && !act_q && (pc < prog_len),
    is_signed_neg_q: neg_a ^ neg_b,
    is_signed_neg_r: neg_a
  };

  rvm_divider u_div (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (dctl),
    .dividend_mag(mag_a),
    .divisor_mag (mag_b),
    .busy        (div_busy),
    .quotient    (div_q),
    .remainder   (div_r)
  );

  function automatic logic [4:0] alu_fl(input logic [4:0] f, input logic [31:0] r);
    alu_fl = {f[FL_D], 2'b00, r[31], (r == 32'd0)};
  endfunction

  // Decode in EXEC; results captured in registers.
  logic [31:0] addr_c, sh_l, sh_r;
  logic        in_rng, take;
  logic [31:0] pc_inc;
  assign pc_inc = pc + 32'd1;
  assign addr_c = (op_q == OP_LOAD || op_q == OP_STORE) ? (ra + imm_q) : imm_q;
  assign in_rng = (addr_c < 32'(MEM_WORDS));
  assign sh_l   = (rb >= 32'd32) ? 32'd0 : (ra << rb[4:0]);
  assign sh_r   = (rb >= 32'd32) ? 32'd0 : (ra >> rb[4:0]);

  logic [AW-1:0] sp_dec, sp_inc;
  assign sp_dec = (sp == '0) ? AW'(MEM_WORDS - 1) : sp - 1'b1;
  assign sp_inc = (32'(sp) + 32'd1 >= 32'(MEM_WORDS)) ? '0 : sp + 1'b1;

  always_comb begin
    case (op_q)
      OP_JZ:   take = flags[FL_Z];
      OP_JNZ:  take = !flags[FL_Z];
      OP_JC:   take = flags[FL_C];
      OP_JNC:  take = !flags[FL_C];
      OP_JS:   take = flags[FL_N];
      OP_JNS:  take = !flags[FL_N];
      OP_JO:   take = flags[FL_V];
      OP_JNO:  take = !flags[FL_V];
      default: take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod <= $signed(ra) * $signed(rb);
    end
  end

  // The product fits when its upper 33 bits are all copies of the sign.
  logic mul_ovf;
  assign mul_ovf = (prod[63:31] != {33{1'b0}}) && (prod[63:31] != {33{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= '0;
      flags <= '0;
      sp    <= AW'(MEM_WORDS - 1);
    end else if (state == ST_WB) begin
      pc    <= pc_from_mem ? mem_rdata : pc_new;
      flags <= flags_new;
      sp    <= sp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      pc_new      <= pc;
      flags_new   <= flags;
      ev_q        <= EV_NONE;
      evv_q       <= '0;
      wr_rf_q     <= 1'b0;
      wr_val_q    <= '0;
      rf_from_mem <= 1'b0;
      pc_from_mem <= 1'b0;
      mem_we_q    <= 1'b0;
      mem_addr_q  <= '0;
      mem_wd_q    <= '0;
      sp_new      <= sp;
      if (act_q) begin
        if (pa_q < 32'(MEM_WORDS)) begin
          mem_we_q   <= 1'b1;
          mem_addr_q <= pa_q[AW-1:0];
          mem_wd_q   <= pv_q;
        end else begin
          ev_q  <= EV_RANGE;
          evv_q <= pa_q;
        end
      end else if (pc < prog_len) begin
        pc_new <= pc_inc;
        case (op_q)
          OP_NOP: ;
          OP_INT: begin
            if (imm_q == 32'd0) begin
              ev_q <= EV_PCHAR; evv_q <= r0v;
            end else if (imm_q == 32'd1) begin
              ev_q <= EV_PINT; evv_q <= r0v;
            end else if (imm_q == 32'd2) begin
              ev_q <= EV_DISP;
            end else begin
              ev_q <= EV_BADINT; evv_q <= imm_q;
            end
          end
          OP_HALT: pc_new <= prog_len;
          OP_LOAD, OP_LOADI: begin
            if (in_rng) begin
              mem_addr_q <= addr_c[AW-1:0];
              rf_from_mem <= 1'b1;
              wr_rf_q <= 1'b1;
            end else begin
              ev_q <= EV_RANGE; evv_q <= addr_c;
            end
          end
          OP_STORE, OP_STOREI: begin
            if (in_rng) begin
              mem_we_q <= 1'b1; mem_addr_q <= addr_c[AW-1:0]; mem_wd_q <= rb;
            end else begin
              ev_q <= EV_RANGE; evv_q <= addr_c;
            end
          end
          OP_SET: begin wr_rf_q <= 1'b1; wr_val_q <= imm_q; end
          OP_ADD: begin
            wr_rf_q <= 1'b1; wr_val_q <= ra + rb; flags_new <= alu_fl(flags, ra + rb);
          end
          OP_SUB: begin
            wr_rf_q <= 1'b1; wr_val_q <= ra - rb; flags_new <= alu_fl(flags, ra - rb);
          end
          OP_MUL, OP_DIV, OP_MOD: ;
          OP_CMP: flags_new <= alu_fl(flags, rd - ra);
          OP_AND: begin
            wr_rf_q <= 1'b1; wr_val_q <= ra & rb; flags_new <= alu_fl(flags, ra & rb);
          end
          OP_OR: begin
            wr_rf_q <= 1'b1; wr_val_q <= ra | rb; flags_new <= alu_fl(flags, ra | rb);
          end
          OP_XOR: begin
            wr_rf_q <= 1'b1; wr_val_q <= ra ^ rb; flags_new <= alu_fl(flags, ra ^ rb);
          end
          OP_NOT: begin
            wr_rf_q <= 1'b1; wr_val_q <= ~ra; flags_new <= alu_fl(flags, ~ra);
          end
          OP_SHL: begin
            wr_rf_q <= 1'b1; wr_val_q <= sh_l; flags_new <= alu_fl(flags, sh_l);
          end
          OP_SHR: begin
            wr_rf_q <= 1'b1; wr_val_q <= sh_r; flags_new <= alu_fl(flags, sh_r);
          end
          OP_JMP:  pc_new <= imm_q;
          OP_JMPR: pc_new <= rd;
          OP_JZ, OP_JNZ, OP_JC, OP_JNC, OP_JS, OP_JNS, OP_JO, OP_JNO: begin
            if (take) pc_new <= imm_q;
          end
          OP_PUSH: begin
            mem_we_q <= 1'b1; mem_addr_q <= sp; mem_wd_q <= rd; sp_new <= sp_dec;
          end
          OP_POP: begin
            mem_addr_q <= sp_inc; rf_from_mem <= 1'b1; wr_rf_q <= 1'b1; sp_new <= sp_inc;
          end
          OP_CALL: begin
            mem_we_q <= 1'b1; mem_addr_q <= sp; mem_wd_q <= pc_inc; sp_new <= sp_dec;
            pc_new <= imm_q;
          end
          OP_CALLR: begin
            mem_we_q <= 1'b1; mem_addr_q <= sp; mem_wd_q <= pc_inc; sp_new <= sp_dec;
            pc_new <= rd;
          end
          OP_RET: begin
            mem_addr_q <= sp_inc; pc_from_mem <= 1'b1; sp_new <= sp_inc;
          end
          default: begin ev_q <= EV_BADOP; evv_q <= {26'd0, op_q}; end
        endcase
        if (op_q == OP_DIV || op_q == OP_MOD) begin
          if (rb == '0) flags_new[FL_D] <= 1'b1;
        end
      end
    end else if (state == ST_MEMRD && op_q == OP_MUL && !act_q && pc < prog_len) begin
      // Multiply results are folded in once the product register holds.
      if (mul_ovf) begin
        flags_new[FL_V] <= 1'b1;
      end else begin
        wr_rf_q   <= 1'b1;
        wr_val_q  <= prod[31:0];
        flags_new <= alu_fl(flags, prod[31:0]);
      end
    end else if (state == ST_DIV && !div_busy && !act_q && rb != '0) begin
      wr_rf_q   <= 1'b1;
      wr_val_q  <= (op_q == OP_DIV) ? div_q : div_r;
      flags_new <= alu_fl(flags, (op_q == OP_DIV) ? div_q : div_r);
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = mem_addr_q;
    mem_wdata  = mem_wd_q;
    rf_we      = 1'b0;
    rf_waddr   = d_q;
    rf_wdata   = rf_from_mem ? mem_rdata : wr_val_q;
    strobe     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt[AW-1:0];
        mem_wdata = '0;
        rf_we     = 1'b1;
        rf_waddr  = clr_cnt[3:0];
        rf_wdata  = '0;
        if (clr_cnt == (AW + 1)'(MEM_WORDS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE:  if (start) state_next = ST_READ;
      ST_READ:  state_next = ST_EXEC;
      ST_EXEC: begin
        if (!act_q && pc < prog_len && op_q == OP_MUL) state_next = ST_MUL;
        else if (dctl.start) state_next = ST_DIV;
        else state_next = ST_MEMRD;
      end
      ST_MUL:   state_next = ST_MEMRD;
      ST_DIV:   if (!div_busy) state_next = ST_MEMRD;
      ST_MEMRD: begin
        mem_we = mem_we_q;
        state_next = ST_WB;
      end
      ST_WB: begin
        rf_we = wr_rf_q;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        strobe = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign next_pc     = pc;
  assign done_res    = (pc >= prog_len);
  assign event_res   = ev_q;
  assign event_value = evv_q;
  assign flag_bits   = flags;

`ifndef SYNTH
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("strobe outside a busy item");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy) else $error("config ready while busy");
  a_strobe_one: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("strobe longer than one cycle");
`endif
endmodule
